// ===== rtl/pltr_pkg.sv =====
// Shared types and constants of the ping loss and round-trip tracker.
// Used by pltr_front, pltr_queue, pltr_back and ping_loss_and_rtt_tracker.
`timescale 1ns / 1ps

package pltr_pkg;

    // Defaults of the top-level parameters
    localparam int HISTORY_DEPTH_DEF    = 64;
    localparam int TIME_WIDTH_DEF       = 48;
    localparam int MAX_DESTINATIONS_DEF = 256;

    // Field widths on the ports
    localparam int SEQ_W   = 32;
    localparam int FTIME_W = 48;
    localparam int DEST_W  = 8;
    localparam int NDEST_W = 9;
    localparam int BURST_W = 16;
    localparam int CNT_W   = 32;

    // Stream word layout
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 312;
    localparam int OUT_USER_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PINGS_PER_DEST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DESTINATIONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS       = 2'd2;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        KIND_SEND  = 1'b0,
        KIND_REPLY = 1'b1
    } t_kind;

    // One classified word handed from the front to the back
    typedef struct packed {
        t_kind             kind;
        logic              sent;
        logic              fresh;
        logic              rtt_valid;
        logic [DEST_W-1:0] dest;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  next_seq;
    } t_work;

endpackage

// ===== rtl/ping_loss_and_rtt_tracker.sv =====
// Top level of the ping loss and round-trip tracker.
// Depends on pltr_pkg, pltr_front, pltr_queue and pltr_back.
`timescale 1ns / 1ps

// Usage
//   Input stream s_axis: one word per send tick or received reply. tuser is
//   the kind (0 send tick, 1 reply). Output stream m_axis: one result word per
//   input word, in order. Configuration is a plain write port (pings per
//   destination, number of destinations, continuous), written while idle.
// Pipeline and rate
//   A word runs through the front stage register, the queue and the back-end
//   result register. One word per cycle while m_axis_tready is high: the ring
//   takes one write or read per cycle, the statistics one word per cycle.
// Reset
//   i_rst_n low at a clock edge clears sequence numbers, counters, the
//   rotation and the queue; min round trip goes to all ones, max to zero.
//   Configuration returns to 1, 1, 0. Ring contents are not cleared; an entry
//   is only used once its probe was sent.
// Stalls
//   When m_axis_tready is low the result word holds, the two-entry queue
//   fills, and s_axis_tready drops once the front stage cannot move on.

module ping_loss_and_rtt_tracker #(
    parameter int HISTORY_DEPTH    = pltr_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_WIDTH       = pltr_pkg::TIME_WIDTH_DEF,
    parameter int MAX_DESTINATIONS = pltr_pkg::MAX_DESTINATIONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pltr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pltr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // time_now[47:0], reply_seq[79:48]
    input  logic [pltr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind[0]
    input  logic [pltr_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // seq_number[31:0], dest_index[39:32], round_trip[87:40],
    // lost_total[119:88], late_total[151:120], reply_total[183:152],
    // round_trip_min[231:184], round_trip_max[279:232], final_loss[311:280]
    output logic [pltr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // sent[0], new_destination[1], round_trip_valid[2]
    output logic [pltr_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    localparam int FTIME_W = pltr_pkg::FTIME_W;
    localparam int SEQ_W   = pltr_pkg::SEQ_W;
    localparam int CNT_W   = pltr_pkg::CNT_W;

    pltr_pkg::t_kind       in_kind;
    logic [TIME_WIDTH-1:0] in_time;
    logic [SEQ_W-1:0]      in_seq;

    logic                  f_valid;
    logic                  f_ready;
    pltr_pkg::t_work       f_work;
    logic [TIME_WIDTH-1:0] f_rtt;

    logic                  q_valid;
    logic                  q_ready;
    pltr_pkg::t_work       q_work;
    logic [TIME_WIDTH-1:0] q_rtt;

    pltr_pkg::t_work       b_work;
    logic [TIME_WIDTH-1:0] b_rtt;
    logic [CNT_W-1:0]      b_loss;
    logic [CNT_W-1:0]      b_late;
    logic [CNT_W-1:0]      b_reply;
    logic [TIME_WIDTH-1:0] b_min;
    logic [TIME_WIDTH-1:0] b_max;
    logic [CNT_W-1:0]      b_final;

    // unpack the input word
    assign in_kind = pltr_pkg::t_kind'(s_axis_tuser[0]);
    assign in_time = (TIME_WIDTH)'(s_axis_tdata[FTIME_W-1:0]);
    assign in_seq  = s_axis_tdata[FTIME_W+SEQ_W-1:FTIME_W];

    pltr_front #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .TIME_WIDTH       (TIME_WIDTH),
        .MAX_DESTINATIONS (MAX_DESTINATIONS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (in_kind),
        .i_time      (in_time),
        .i_seq       (in_seq),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_work      (f_work),
        .o_rtt       (f_rtt)
    );

    pltr_queue #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_work  (f_work),
        .i_rtt   (f_rtt),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_work  (q_work),
        .o_rtt   (q_rtt)
    );

    pltr_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_work  (q_work),
        .i_rtt   (q_rtt),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_work  (b_work),
        .o_rtt   (b_rtt),
        .o_loss  (b_loss),
        .o_late  (b_late),
        .o_reply (b_reply),
        .o_min   (b_min),
        .o_max   (b_max),
        .o_final (b_final)
    );

    // pack the result word
    assign m_axis_tdata = {
        b_final,
        (FTIME_W)'(b_max),
        (FTIME_W)'(b_min),
        b_reply,
        b_late,
        b_loss,
        (FTIME_W)'(b_rtt),
        b_work.dest,
        b_work.seq
    };
    assign m_axis_tuser = {b_work.rtt_valid, b_work.fresh, b_work.sent};

endmodule

// ===== rtl/pltr_front.sv =====
// Front end of the tracker: accepts words, runs the send scheduler and the
// send-time ring, and hands classified words on. Depends on pltr_pkg.
`timescale 1ns / 1ps

module pltr_front #(
    parameter int HISTORY_DEPTH    = pltr_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_WIDTH       = pltr_pkg::TIME_WIDTH_DEF,
    parameter int MAX_DESTINATIONS = pltr_pkg::MAX_DESTINATIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pltr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pltr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  pltr_pkg::t_kind                  i_kind,
    input  logic [TIME_WIDTH-1:0]            i_time,
    input  logic [pltr_pkg::SEQ_W-1:0]       i_seq,
    output logic                             o_valid,
    input  logic                             i_ready,
    output pltr_pkg::t_work                  o_work,
    output logic [TIME_WIDTH-1:0]            o_rtt
);

    localparam int SEQ_W   = pltr_pkg::SEQ_W;
    localparam int NDEST_W = pltr_pkg::NDEST_W;
    localparam int BURST_W = pltr_pkg::BURST_W;
    localparam int DEST_W  = pltr_pkg::DEST_W;
    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int SUM_W   = IDX_W + 2;
    localparam int MEM_W   = TIME_WIDTH + SEQ_W;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(HISTORY_DEPTH);
    // 2^32 mod depth: ring index offset of sequences from before the wrap
    localparam longint unsigned WRAP_REM = (64'd1 << SEQ_W) % HISTORY_DEPTH;
    localparam logic [SUM_W-1:0] WRAP_REM_S = SUM_W'(WRAP_REM);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    // configuration
    logic [BURST_W-1:0] r_ppd;
    logic [NDEST_W-1:0] r_ndest;
    logic               r_cont;

    // scheduler state
    logic [SEQ_W-1:0]   r_next_seq;
    logic [IDX_W-1:0]   r_wptr;
    logic               r_wrapped;
    logic [BURST_W-1:0] r_bp;
    logic [NDEST_W-1:0] r_dr;
    logic               r_stopped;

    // stage register and ring
    logic                    r_fv;
    pltr_pkg::t_work         r_f;
    pltr_pkg::t_work         n_f;
    logic [TIME_WIDTH-1:0]   r_ftime;
    logic                    r_win;
    logic [MEM_W-1:0]        r_ring [HISTORY_DEPTH];
    logic [MEM_W-1:0]        r_rd_word;

    logic                    accept;
    logic                    is_send;
    logic [NDEST_W-1:0]      ndest_eff;
    logic [BURST_W-1:0]      burst;
    logic [BURST_W-1:0]      bp_eff;
    logic [BURST_W:0]        bp_inc;
    logic [BURST_W-1:0]      bp_next;
    logic                    start;
    logic                    pass_over;
    logic                    can_send;
    logic                    issue;
    logic [NDEST_W-1:0]      dr_use;
    logic [SEQ_W-1:0]        seq_gap;
    logic                    ahead;
    logic                    win_ok;
    logic [SUM_W-1:0]        a_sum;
    logic [SUM_W-1:0]        a_red;
    logic [SUM_W-1:0]        b_sum;
    logic [SUM_W-1:0]        b_red;
    logic [IDX_W-1:0]        rd_idx;
    logic                    ring_we;
    logic                    ring_re;
    logic                    hit;

    assign o_ready = !r_fv || i_ready;
    assign accept  = i_valid && o_ready;
    assign is_send = (i_kind == pltr_pkg::KIND_SEND);

    // destination rotation and burst position
    always_comb begin
        if (int'(r_ndest) > MAX_DESTINATIONS) begin
            ndest_eff = NDEST_W'(MAX_DESTINATIONS);
        end else begin
            ndest_eff = r_ndest;
        end
        burst     = (r_ppd == '0) ? BURST_W'(1) : r_ppd;
        bp_eff    = (r_bp >= burst) ? '0 : r_bp;
        start     = (bp_eff == '0);
        pass_over = start && (r_dr >= ndest_eff);
        can_send  = !r_stopped && (ndest_eff != '0);
        issue     = can_send && !(pass_over && !r_cont);
        if (!start) begin
            dr_use = r_dr;
        end else if (pass_over) begin
            dr_use = NDEST_W'(1);
        end else begin
            dr_use = r_dr + NDEST_W'(1);
        end
        bp_inc  = {1'b0, bp_eff} + (BURST_W + 1)'(1);
        bp_next = (bp_inc >= {1'b0, burst}) ? '0 : bp_inc[BURST_W-1:0];
    end

    // reply window check and ring index of the reply's sequence
    always_comb begin
        seq_gap = r_next_seq - i_seq;
        ahead   = (i_seq > r_next_seq);
        win_ok  = (seq_gap != '0) && (seq_gap <= SEQ_W'(HISTORY_DEPTH))
                  && (!ahead || r_wrapped);
        a_sum   = {2'b00, r_wptr} + DEPTH_S - seq_gap[SUM_W-1:0];
        a_red   = (a_sum >= DEPTH_S) ? (a_sum - DEPTH_S) : a_sum;
        b_sum   = a_red + WRAP_REM_S;
        b_red   = (b_sum >= DEPTH_S) ? (b_sum - DEPTH_S) : b_sum;
        rd_idx  = ahead ? b_red[IDX_W-1:0] : a_red[IDX_W-1:0];
    end

    assign ring_we = accept && is_send && issue;
    assign ring_re = accept && !is_send;

    // classified word for the stage register
    always_comb begin
        n_f          = '0;
        n_f.kind     = i_kind;
        n_f.next_seq = r_next_seq;
        if (is_send) begin
            if (issue) begin
                n_f.sent     = 1'b1;
                n_f.fresh    = start;
                n_f.dest     = DEST_W'(dr_use - NDEST_W'(1));
                n_f.seq      = r_next_seq;
                n_f.next_seq = r_next_seq + SEQ_W'(1);
            end
        end else begin
            n_f.seq = i_seq;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppd      <= BURST_W'(1);
            r_ndest    <= NDEST_W'(1);
            r_cont     <= 1'b0;
            r_next_seq <= '0;
            r_wptr     <= '0;
            r_wrapped  <= 1'b0;
            r_bp       <= '0;
            r_dr       <= '0;
            r_stopped  <= 1'b0;
            r_fv       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pltr_pkg::CFG_PINGS_PER_DEST:   r_ppd   <= i_cfg_data;
                    pltr_pkg::CFG_NUM_DESTINATIONS: r_ndest <= i_cfg_data[NDEST_W-1:0];
                    pltr_pkg::CFG_CONTINUOUS:       r_cont  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept && is_send && can_send) begin
                if (issue) begin
                    r_dr       <= dr_use;
                    r_bp       <= bp_next;
                    r_next_seq <= r_next_seq + SEQ_W'(1);
                    if (r_next_seq == '1) begin
                        r_wrapped <= 1'b1;
                        r_wptr    <= '0;
                    end else begin
                        r_wptr <= (r_wptr == LAST_IDX) ? '0 : r_wptr + IDX_W'(1);
                    end
                end else begin
                    // pass is over: keep the cleared burst position and stop
                    r_bp      <= bp_eff;
                    r_stopped <= 1'b1;
                end
            end
            if (accept) begin
                r_fv <= 1'b1;
            end else if (i_ready) begin
                r_fv <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f     <= n_f;
            r_ftime <= i_time;
            r_win   <= !is_send && win_ok;
        end
    end

    // send-time ring: time stamp and sequence tag per entry
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wptr] <= {r_next_seq, i_time};
        end
        if (ring_re) begin
            r_rd_word <= r_ring[rd_idx];
        end
    end

    // round trip of a reply once the ring word is back
    assign hit = r_win && (r_rd_word[MEM_W-1:TIME_WIDTH] == r_f.seq);

    always_comb begin
        o_work           = r_f;
        o_work.rtt_valid = hit;
        o_rtt            = hit ? (r_ftime - r_rd_word[TIME_WIDTH-1:0]) : '0;
    end

    assign o_valid = r_fv;

    // a finished pass stays finished until reset
    a_stopped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    // every issued probe takes exactly the next sequence number
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |=> (r_next_seq == $past(r_next_seq) + SEQ_W'(1)))
        else $error("sequence counter did not step on a probe");

endmodule

// ===== rtl/pltr_queue.sv =====
// Short queue between front and back of the tracker.
// Holds classified words and their round trips. Depends on pltr_pkg.
`timescale 1ns / 1ps

module pltr_queue #(
    parameter int TIME_WIDTH = pltr_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pltr_pkg::t_work       i_work,
    input  logic [TIME_WIDTH-1:0] i_rtt,
    output logic                  o_valid,
    input  logic                  i_ready,
    output pltr_pkg::t_work       o_work,
    output logic [TIME_WIDTH-1:0] o_rtt
);

    localparam int DEPTH = pltr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pltr_pkg::t_work       r_work [DEPTH];
    logic [TIME_WIDTH-1:0] r_rtt  [DEPTH];
    logic [PTR_W-1:0]      r_wp;
    logic [PTR_W-1:0]      r_rp;
    logic [CNT_W-1:0]      r_cnt;
    logic                  push;
    logic                  pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_work  = r_work[r_rp];
    assign o_rtt   = r_rtt[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_work[r_wp] <= i_work;
            r_rtt[r_wp]  <= i_rtt;
        end
    end

    // an empty queue has its pointers together
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("queue empty with pointers apart");

endmodule

// ===== rtl/pltr_back.sv =====
// Back end of the tracker: applies replies to the loss, late, reply and
// round-trip statistics and holds the result word. Depends on pltr_pkg.
`timescale 1ns / 1ps

module pltr_back #(
    parameter int TIME_WIDTH = pltr_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  pltr_pkg::t_work              i_work,
    input  logic [TIME_WIDTH-1:0]        i_rtt,
    output logic                         o_valid,
    input  logic                         i_ready,
    output pltr_pkg::t_work              o_work,
    output logic [TIME_WIDTH-1:0]        o_rtt,
    output logic [pltr_pkg::CNT_W-1:0]   o_loss,
    output logic [pltr_pkg::CNT_W-1:0]   o_late,
    output logic [pltr_pkg::CNT_W-1:0]   o_reply,
    output logic [TIME_WIDTH-1:0]        o_min,
    output logic [TIME_WIDTH-1:0]        o_max,
    output logic [pltr_pkg::CNT_W-1:0]   o_final
);

    localparam int CNT_W = pltr_pkg::CNT_W;
    localparam int SEQ_W = pltr_pkg::SEQ_W;

    logic [SEQ_W-1:0]      r_exp;
    logic [CNT_W-1:0]      r_loss;
    logic [CNT_W-1:0]      r_late;
    logic [CNT_W-1:0]      r_reply;
    logic [TIME_WIDTH-1:0] r_min;
    logic [TIME_WIDTH-1:0] r_max;
    logic                  r_ov;
    pltr_pkg::t_work       r_o_work;
    logic [TIME_WIDTH-1:0] r_o_rtt;

    logic                  pop;
    logic                  is_reply;

    assign o_ready  = !r_ov || i_ready;
    assign pop      = i_valid && o_ready;
    assign is_reply = (i_work.kind == pltr_pkg::KIND_REPLY);

    // statistics and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp   <= '0;
            r_loss  <= '0;
            r_late  <= '0;
            r_reply <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (pop && is_reply) begin
                r_reply <= r_reply + CNT_W'(1);
                // in order, gap, or late arrival
                priority if (i_work.seq == r_exp) begin
                    r_exp <= r_exp + SEQ_W'(1);
                end else if (i_work.seq > r_exp) begin
                    r_loss <= r_loss + (i_work.seq - r_exp);
                    r_exp  <= i_work.seq + SEQ_W'(1);
                end else begin
                    r_late <= r_late + CNT_W'(1);
                    r_loss <= r_loss - CNT_W'(1);
                end
                if (i_work.rtt_valid) begin
                    if (i_rtt < r_min) begin
                        r_min <= i_rtt;
                    end
                    if (i_rtt > r_max) begin
                        r_max <= i_rtt;
                    end
                end
            end
            if (pop) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // per-word result fields
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_work <= i_work;
            r_o_rtt  <= i_rtt;
        end
    end

    // statistics only move on a pop, so they show this word's values
    assign o_valid = r_ov;
    assign o_work  = r_o_work;
    assign o_rtt   = r_o_rtt;
    assign o_loss  = r_loss;
    assign o_late  = r_late;
    assign o_reply = r_reply;
    assign o_min   = r_min;
    assign o_max   = r_max;
    assign o_final = r_loss + (r_o_work.next_seq - r_exp);

    // a send word leaves the reply count alone
    a_send_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !is_reply) |=> $stable(r_reply))
        else $error("reply count moved on a send word");

    // once a valid round trip is in, min never exceeds max
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && is_reply && i_work.rtt_valid) |=> (r_min <= r_max))
        else $error("round-trip min above max");

endmodule

// ===== tb/sv/tracker_monitor.sv =====
// Result checker for the ping loss and round-trip tracker testbench.
// Depends on pltr_pkg; watches the config port and both streams of the block.
`timescale 1ns / 1ps

module tracker_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pltr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pltr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // time_now[47:0], reply_seq[79:48]
    input  logic [pltr_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // kind[0]
    input  logic [pltr_pkg::IN_USER_W-1:0]     i_s_tuser,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // seq_number, dest_index, round_trip, lost_total, late_total,
    // reply_total, round_trip_min, round_trip_max, final_loss
    input  logic [pltr_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    // sent[0], new_destination[1], round_trip_valid[2]
    input  logic [pltr_pkg::OUT_USER_W-1:0]    i_m_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import pltr_pkg::*;

    localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
    localparam int DEST_LIMIT = MAX_DESTINATIONS_DEF;

    typedef struct {
        logic               sent;
        logic               fresh;
        logic               trip_valid;
        logic [SEQ_W-1:0]   seq;
        logic [DEST_W-1:0]  dest;
        logic [FTIME_W-1:0] trip;
        logic [CNT_W-1:0]   lost;
        logic [CNT_W-1:0]   late;
        logic [CNT_W-1:0]   replies;
        logic [FTIME_W-1:0] trip_min;
        logic [FTIME_W-1:0] trip_max;
        logic [CNT_W-1:0]   final_loss;
    } t_probe_result;

    // local copy of the registers
    logic [BURST_W-1:0] pings_per_dest;
    logic [NDEST_W-1:0] dest_count;
    logic               continuous_mode;

    // tracker state
    logic [SEQ_W-1:0]   next_seq;
    logic [SEQ_W-1:0]   expected_seq;
    logic [CNT_W-1:0]   loss_count;
    logic [CNT_W-1:0]   late_count;
    logic [CNT_W-1:0]   reply_count;
    logic [FTIME_W-1:0] trip_min;
    logic [FTIME_W-1:0] trip_max;
    logic [FTIME_W-1:0] ring_time [RING_DEPTH];
    logic [SEQ_W-1:0]   ring_tag [RING_DEPTH];
    bit                 ring_filled [RING_DEPTH];
    int unsigned        burst_pos;
    int unsigned        dest_round;
    bit                 stopped;

    t_probe_result expected_words[$];
    int            mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Advance the tracker by one word and return the result it should give
    function automatic t_probe_result track_word(t_kind kind, logic [FTIME_W-1:0] now,
                                                 logic [SEQ_W-1:0] rseq);
        t_probe_result      r;
        int unsigned        ndest;
        int unsigned        burst;
        int unsigned        slot;
        logic [SEQ_W-1:0]   seq_gap;
        logic [FTIME_W-1:0] trip;
        bit                 issue;
        r = '{default: 0};
        if (kind == KIND_SEND) begin
            ndest = (dest_count > DEST_LIMIT) ? DEST_LIMIT : dest_count;
            burst = (pings_per_dest == 0) ? 1 : pings_per_dest;
            if (!stopped && ndest != 0) begin
                issue = 1'b1;
                if (burst_pos >= burst)
                    burst_pos = 0;
                // burst start: move on to the next destination, restart the rotation or end the pass
                if (burst_pos == 0) begin
                    if (dest_round >= ndest) begin
                        if (!continuous_mode) begin
                            stopped = 1'b1;
                            issue = 1'b0;
                        end else begin
                            dest_round = 0;
                        end
                    end
                    if (issue) begin
                        dest_round++;
                        r.fresh = 1'b1;
                    end
                end
                if (issue) begin
                    slot = next_seq % RING_DEPTH;
                    ring_time[slot] = now;
                    ring_tag[slot] = next_seq;
                    ring_filled[slot] = 1'b1;
                    r.sent = 1'b1;
                    r.seq = next_seq;
                    r.dest = DEST_W'(dest_round - 1);
                    next_seq++;
                    burst_pos++;
                    if (burst_pos >= burst)
                        burst_pos = 0;
                end
            end
        end else begin
            seq_gap = next_seq - rseq;
            slot = rseq % RING_DEPTH;
            r.seq = rseq;
            // only a probe still held in the ring gives a round trip
            if (seq_gap >= 1 && seq_gap <= RING_DEPTH && ring_filled[slot]
                    && ring_tag[slot] == rseq) begin
                trip = now - ring_time[slot];
                r.trip = trip;
                r.trip_valid = 1'b1;
                if (trip < trip_min)
                    trip_min = trip;
                if (trip > trip_max)
                    trip_max = trip;
            end
            reply_count++;
            if (rseq == expected_seq) begin
                expected_seq++;
            end else if (rseq > expected_seq) begin
                loss_count += rseq - expected_seq;
                expected_seq = rseq + 1;
            end else begin
                late_count++;
                loss_count--;
            end
        end
        r.lost = loss_count;
        r.late = late_count;
        r.replies = reply_count;
        r.trip_min = trip_min;
        r.trip_max = trip_max;
        r.final_loss = loss_count + (next_seq - expected_seq);
        return r;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_probe_result want;
        if (!i_rst_n) begin
            pings_per_dest = 1;
            dest_count = 1;
            continuous_mode = 1'b0;
            next_seq = '0;
            expected_seq = '0;
            loss_count = '0;
            late_count = '0;
            reply_count = '0;
            trip_min = '1;
            trip_max = '0;
            burst_pos = 0;
            dest_round = 0;
            stopped = 1'b0;
            foreach (ring_filled[i])
                ring_filled[i] = 1'b0;
            expected_words.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PINGS_PER_DEST:   pings_per_dest = i_cfg_data[BURST_W-1:0];
                    CFG_NUM_DESTINATIONS: dest_count = i_cfg_data[NDEST_W-1:0];
                    CFG_CONTINUOUS:       continuous_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            // accepted input word
            if (i_s_tvalid && i_s_tready)
                expected_words.insert(expected_words.size(),
                                      track_word(t_kind'(i_s_tuser[0]),
                                                 i_s_tdata[FTIME_W-1:0],
                                                 i_s_tdata[FTIME_W +: SEQ_W]));
            // accepted result word
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("sent", want.sent, i_m_tuser[0]);
                    check_field("new_destination", want.fresh, i_m_tuser[1]);
                    check_field("round_trip_valid", want.trip_valid, i_m_tuser[2]);
                    check_field("seq_number", want.seq, i_m_tdata[31:0]);
                    check_field("dest_index", want.dest, i_m_tdata[39:32]);
                    check_field("round_trip", want.trip, i_m_tdata[87:40]);
                    check_field("lost_total", want.lost, i_m_tdata[119:88]);
                    check_field("late_total", want.late, i_m_tdata[151:120]);
                    check_field("reply_total", want.replies, i_m_tdata[183:152]);
                    check_field("round_trip_min", want.trip_min, i_m_tdata[231:184]);
                    check_field("round_trip_max", want.trip_max, i_m_tdata[279:232]);
                    check_field("final_loss", want.final_loss, i_m_tdata[311:280]);
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the ping loss and round-trip tracker testbench: clock, reset, stimulus.
// Depends on pltr_pkg, ping_loss_and_rtt_tracker and tracker_monitor.
`timescale 1ns / 1ps

module testbench;
    import pltr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [FTIME_W-1:0] TIME_BASE = 48'hFFFF_FFFF_8000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_PINGS_PER_DEST;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    bit               send_idle = 1'b1;
    bit               recv_idle = 1'b1;
    int               hold_reqs = 0;
    int               hold_done = 0;
    int               hold_left = 0;
    int               stall_left = 0;
    int               cur_ndest = 1;
    logic [SEQ_W-1:0] sent_count = '0;
    logic [SEQ_W-1:0] reply_next = '0;
    logic [FTIME_W-1:0] now_t = TIME_BASE;

    ping_loss_and_rtt_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tracker_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: long hold on request, else short random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_done != hold_reqs) begin
            hold_done = hold_reqs;
            hold_left = 299;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (recv_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one word, with an occasional gap first, and wait until it is taken
    task automatic push_word(input t_kind kind, input logic [FTIME_W-1:0] stamp,
                             input logic [SEQ_W-1:0] rseq);
        int gap;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rseq, stamp};
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_tick(input logic [FTIME_W-1:0] stamp);
        push_word(KIND_SEND, stamp, $urandom);
        if (cur_ndest != 0)
            sent_count++;
    endtask

    task automatic reply_word(input logic [SEQ_W-1:0] rseq, input logic [FTIME_W-1:0] stamp);
        push_word(KIND_REPLY, stamp, rseq);
    endtask

    // Drain: stop offering and wait until every result is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input int pings, input int ndest, input bit cont);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PINGS_PER_DEST;
        i_cfg_data <= CFG_DATA_W'(pings);
        @(posedge i_clk);
        i_cfg_index <= CFG_NUM_DESTINATIONS;
        i_cfg_data <= CFG_DATA_W'(ndest);
        @(posedge i_clk);
        i_cfg_index <= CFG_CONTINUOUS;
        i_cfg_data <= CFG_DATA_W'(cont);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_ndest = ndest;
    endtask

    // One random word: mostly probes and replies to recent probes
    task automatic random_item(input int send_pct, input bit noisy);
        int               pick;
        logic [SEQ_W-1:0] rseq;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic [FTIME_W-1:0] stamp;
        now_t = now_t + FTIME_W'($urandom_range(0, 60));
        lo = $urandom;
        hi = $urandom;
        stamp = noisy ? {hi[15:0], lo} : now_t;
        if ($urandom_range(1, 100) <= send_pct) begin
            send_tick(stamp);
        end else begin
            if (sent_count - reply_next > 60)
                reply_next = sent_count - 8;
            pick = $urandom_range(0, 99);
            if (pick < 35 && reply_next != sent_count) begin
                rseq = reply_next;
                reply_next++;
            end else if (pick < 75) begin
                rseq = sent_count - $urandom_range(1, 64);
            end else if (pick < 85) begin
                rseq = sent_count - $urandom_range(65, 80);
            end else if (pick < 93) begin
                rseq = sent_count + $urandom_range(0, 3);
            end else begin
                rseq = $urandom;
            end
            reply_word(rseq, stamp);
        end
    endtask

    initial begin : stimulus
        int pings;
        int ndest;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first probe on reset settings, then continuous
        send_tick(TIME_BASE + 1000);
        wait_idle();
        set_config(1, 1, 1);
        send_tick(TIME_BASE + 1010);
        reply_word(0, TIME_BASE + 1100);
        reply_word(1, TIME_BASE + 1050);
        // gap, late repeat, unwritten slot inside the window, wrap to zero
        reply_word(5, TIME_BASE + 1200);
        reply_word(1, TIME_BASE + 1210);
        reply_word(32'hFFFF_FFFF, TIME_BASE + 1220);
        reply_word(0, TIME_BASE + 1230);
        // no destinations, zero burst length
        wait_idle();
        set_config(0, 0, 1);
        send_tick(TIME_BASE + 1300);
        reply_word(1, TIME_BASE + 1310);
        // short rotation restarts
        wait_idle();
        set_config(0, 3, 1);
        for (int k = 0; k < 4; k++)
            send_tick(TIME_BASE + 1400 + 10 * k);
        // longest burst, destination count above the maximum
        wait_idle();
        set_config(65535, 511, 1);
        for (int k = 0; k < 3; k++)
            send_tick(TIME_BASE + 1500 + 10 * k);
        reply_word(sent_count - 1, TIME_BASE + 1600);
        // burst shrunk below the current position
        wait_idle();
        set_config(2, 511, 1);
        send_tick(TIME_BASE + 1700);
        send_tick(TIME_BASE + 1710);
        now_t = TIME_BASE + 2000;

        // Random phases with varied settings
        for (int p = 0; p < 7; p++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: pings = 0;
                1: pings = 1;
                2, 3: pings = $urandom_range(2, 6);
                4: pings = $urandom_range(7, 40);
                default: pings = 65535;
            endcase
            case ($urandom_range(0, 5))
                0: ndest = 0;
                1: ndest = 1;
                2: ndest = $urandom_range(2, 8);
                3: ndest = 256;
                4: ndest = $urandom_range(257, 511);
                default: ndest = $urandom_range(9, 255);
            endcase
            // first phase walks far through the destination list
            if (p == 0) begin
                pings = 1;
                ndest = 300;
            end
            set_config(pings, ndest, 1);
            send_idle = (p % 3 != 2);
            recv_idle = (p % 3 != 2);
            if (p == 3) begin
                send_idle = 1'b0;
                hold_reqs++;
            end
            for (int k = 0; k < 240; k++)
                random_item((p == 0) ? 70 : 50, 1'b0);
        end

        // Round-trip extremes: zero, across the time wrap, time going backward
        wait_idle();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        set_config(1, 1, 1);
        send_tick(48'hFFFF_FFFF_FFFF);
        reply_word(sent_count - 1, 48'hFFFF_FFFF_FFFF);
        send_tick(48'hFFFF_FFFF_FFFF);
        reply_word(sent_count - 1, 48'd5);
        send_tick(48'd100);
        reply_word(sent_count - 1, 48'd40);

        // One pass only: the tracker stops, replies still count
        wait_idle();
        set_config(3, 2, 0);
        now_t = 48'd1000;
        for (int k = 0; k < 12; k++) begin
            now_t = now_t + 7;
            send_tick(now_t);
        end
        for (int k = 0; k < 40; k++)
            random_item(50, 1'b1);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
